// File: sv/bbc_pkg.sv
// shared types, constants and helper functions for the bracket balance checker
package bbc_pkg;

    // default sizing
    localparam int DEF_STACK_DEPTH     = 32;
    localparam int DEF_MAX_LINE_LENGTH = 4096;

    // fixed field widths
    localparam int SYM_W = 8;
    localparam int POS_W = 12;
    localparam int POS_MAX = 4095;

    // bracket characters
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_LANGLE = 8'h3C;
    localparam logic [SYM_W-1:0] CH_RANGLE = 8'h3E;
    localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;

    // opener codes as stored on the stack
    localparam logic [1:0] OP_PAREN = 2'd0;
    localparam logic [1:0] OP_ANGLE = 2'd1;
    localparam logic [1:0] OP_BRACK = 2'd2;
    localparam logic [1:0] OP_BRACE = 2'd3;

    // result kinds
    localparam logic RK_STATUS = 1'b0;
    localparam logic RK_CLOSER = 1'b1;

    typedef enum logic [1:0] {
        LS_BALANCED   = 2'd0,
        LS_CORRUPTED  = 2'd1,
        LS_INCOMPLETE = 2'd2,
        LS_OVERFLOW   = 2'd3
    } line_status_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_of_line;
    } in_beat_t;

    typedef struct packed {
        logic             result_kind;
        line_status_t     line_status;
        logic [POS_W-1:0] error_position;
        logic [SYM_W-1:0] offending_symbol;
        logic [SYM_W-1:0] closer_symbol;
        logic             final_result;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_STATUS,
        ST_READ,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;      // latch the input beat
        logic push;         // push opener of the input beat
        logic fault;        // record a fault on the input beat
        logic fault_ovf;    // that fault is an overflow, else corruption
        logic pop_read;     // read the top of stack
        logic match;        // compare popped opener with saved symbol
        logic advance;      // step the character position
        logic load_status;  // load status result into output register
        logic drain_read;   // read next opener for completion
        logic load_closer;  // load closer result into output register
        logic clear;        // clear line state
    } bbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_opener;
        logic in_eol;       // end of line flag of the beat on the input
        logic stack_empty;
        logic stack_full;
        logic line_ok;
        logic saved_eol;
        logic incomplete;
        logic drain_done;
    } bbc_stat_t;

    // opener lookup: {hit, code}
    function automatic logic [2:0] opener_lookup(input logic [SYM_W-1:0] sym);
        logic [2:0] r;
        case (sym)
            CH_LPAREN: r = {1'b1, OP_PAREN};
            CH_LANGLE: r = {1'b1, OP_ANGLE};
            CH_LBRACK: r = {1'b1, OP_BRACK};
            CH_LBRACE: r = {1'b1, OP_BRACE};
            default:   r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] closer_of(input logic [1:0] code);
        logic [SYM_W-1:0] r;
        case (code)
            OP_PAREN: r = CH_RPAREN;
            OP_ANGLE: r = CH_RANGLE;
            OP_BRACK: r = CH_RBRACK;
            OP_BRACE: r = CH_RBRACE;
            default:  r = CH_RPAREN;
        endcase
        return r;
    endfunction

endpackage

// File: sv/bbc_ram.sv
// generic single-write, single-read RAM with registered read data
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/bbc_ctrl.sv
// sequencing state machine of the bracket balance checker
module bbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  bbc_pkg::bbc_stat_t stat,
    output bbc_pkg::bbc_cmd_t  cmd
);
    import bbc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        in_fire;
    logic        out_free;
    logic        out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // state and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (stat.line_ok && !stat.is_opener && !stat.stack_empty) begin
                        state_next = ST_MATCH;
                    end else if (stat.in_eol) begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_MATCH: begin
                state_next = stat.saved_eol ? ST_STATUS : ST_IDLE;
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = stat.incomplete ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = stat.drain_done ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd      = '0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.capture = 1'b1;
                    if (stat.line_ok && stat.is_opener) begin
                        cmd.push      = !stat.stack_full;
                        cmd.fault     = stat.stack_full;
                        cmd.fault_ovf = 1'b1;
                        cmd.advance   = 1'b1;
                    end else if (stat.line_ok && stat.stack_empty) begin
                        cmd.fault   = 1'b1;
                        cmd.advance = 1'b1;
                    end else if (stat.line_ok) begin
                        cmd.pop_read = 1'b1;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_MATCH: begin
                cmd.match   = 1'b1;
                cmd.advance = 1'b1;
            end
            ST_STATUS: begin
                if (out_free) begin
                    cmd.load_status = 1'b1;
                    cmd.clear       = !stat.incomplete;
                    out_load        = 1'b1;
                end
            end
            ST_READ: begin
                cmd.drain_read = 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load_closer = 1'b1;
                    cmd.clear       = stat.drain_done;
                    out_load        = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // result valid tracking
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

// File: sv/bbc_dp.sv
// datapath: opener stack, line state, fault record and result register
module bbc_dp #(
    parameter int STACK_DEPTH     = bbc_pkg::DEF_STACK_DEPTH,
    parameter int MAX_LINE_LENGTH = bbc_pkg::DEF_MAX_LINE_LENGTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bbc_pkg::in_beat_t  s_data,
    output bbc_pkg::out_beat_t m_data,
    input  bbc_pkg::bbc_cmd_t  cmd,
    output bbc_pkg::bbc_stat_t stat
);
    import bbc_pkg::*;

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int POS_CAP_I = (MAX_LINE_LENGTH - 1 > POS_MAX) ? POS_MAX
                                                             : MAX_LINE_LENGTH - 1;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  idx_reg;
    line_status_t      cond_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  err_pos_reg;
    logic [SYM_W-1:0]  err_sym_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              eol_reg;
    out_beat_t         out_reg;

    logic [2:0]        op_hit;
    logic [1:0]        rd_code;
    logic [SYM_W-1:0]  rd_closer;
    logic              mismatch;
    logic              fault_now;
    logic [LVL_W-1:0]  level_dec;
    logic [LVL_W-1:0]  idx_dec;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;

    // opener decode and popped-entry check
    assign op_hit    = opener_lookup(s_data.symbol);
    assign rd_closer = closer_of(rd_code);
    assign mismatch  = (rd_closer != sym_reg);
    assign fault_now = cmd.fault || (cmd.match && mismatch);
    assign level_dec = level_reg - LVL_W'(1);
    assign idx_dec   = idx_reg - LVL_W'(1);

    // stack storage
    assign ram_rd_en   = cmd.pop_read || cmd.drain_read;
    assign ram_rd_addr = cmd.drain_read ? idx_dec[ADDR_W-1:0] : level_dec[ADDR_W-1:0];

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (level_reg[ADDR_W-1:0]),
        .wr_data (op_hit[1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_code)
    );

    // status toward the controller
    assign stat.is_opener   = op_hit[2];
    assign stat.in_eol      = s_data.end_of_line;
    assign stat.stack_empty = (level_reg == '0);
    assign stat.stack_full  = (level_reg == LVL_W'(STACK_DEPTH));
    assign stat.line_ok     = (cond_reg == LS_BALANCED);
    assign stat.saved_eol   = eol_reg;
    assign stat.incomplete  = (cond_reg == LS_BALANCED) && (level_reg != '0);
    assign stat.drain_done  = (idx_reg == '0);

    // input beat capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eol_reg <= 1'b0;
        end else if (cmd.capture) begin
            eol_reg <= s_data.end_of_line;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg <= s_data.symbol;
        end
    end

    // line state: stack level, condition, position, first fault
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            level_reg   <= '0;
            cond_reg    <= LS_BALANCED;
            pos_reg     <= '0;
            err_pos_reg <= '0;
            err_sym_reg <= '0;
        end else begin
            if (cmd.push) begin
                level_reg <= level_reg + LVL_W'(1);
            end else if (cmd.match) begin
                level_reg <= level_dec;
            end
            if (fault_now) begin
                cond_reg    <= cmd.fault_ovf ? LS_OVERFLOW : LS_CORRUPTED;
                err_pos_reg <= pos_reg;
                err_sym_reg <= cmd.match ? sym_reg : s_data.symbol;
            end
            if (cmd.advance && (pos_reg < POS_CAP)) begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // completion drain index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.load_status) begin
            idx_reg <= level_reg;
        end else if (cmd.drain_read) begin
            idx_reg <= idx_dec;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_status) begin
            out_reg.result_kind      <= RK_STATUS;
            out_reg.line_status      <= stat.incomplete ? LS_INCOMPLETE : cond_reg;
            out_reg.error_position   <= err_pos_reg;
            out_reg.offending_symbol <= err_sym_reg;
            out_reg.closer_symbol    <= '0;
            out_reg.final_result     <= !stat.incomplete;
        end else if (cmd.load_closer) begin
            out_reg.result_kind      <= RK_CLOSER;
            out_reg.line_status      <= LS_INCOMPLETE;
            out_reg.error_position   <= '0;
            out_reg.offending_symbol <= '0;
            out_reg.closer_symbol    <= rd_closer;
            out_reg.final_result     <= stat.drain_done;
        end
    end

    assign m_data = out_reg;

endmodule

// File: sv/bracket_balance_checker_top.sv
// top level of the bracket balance checker
// Checks one text line at a time for balanced brackets ( < [ {, one character byte per
// input beat, with end_of_line on the last byte. Openers and bytes on an empty stack or
// after a fault are handled on acceptance; any other closer also passes a match state,
// since the popped opener comes from the stack RAM's registered read port. After the
// last byte one status beat follows; an incomplete line then yields its missing closers
// innermost first, each read from the RAM in a read state and loaded in an emit state,
// and input is held off until the last result of the line has been loaded into the
// output register. A result waiting at the output only stalls the block when a further
// result is due. Fault positions count from zero and saturate at MAX_LINE_LENGTH-1
// (4095 at most); a push past STACK_DEPTH reports stack overflow and no closers.
module bracket_balance_checker_top #(
    parameter int STACK_DEPTH     = bbc_pkg::DEF_STACK_DEPTH,
    parameter int MAX_LINE_LENGTH = bbc_pkg::DEF_MAX_LINE_LENGTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bbc_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bbc_pkg::out_beat_t m_data
);
    import bbc_pkg::*;

    bbc_cmd_t  cmd;
    bbc_stat_t stat;

    // sequencing
    bbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // stack, line state and result register
    bbc_dp #(
        .STACK_DEPTH     (STACK_DEPTH),
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// File: tb/bracket_balance_checker_top_test.sv
// self-checking testbench for the bracket balance checker: random lines, stalls, drain pauses
`timescale 1ns / 1ps

module bracket_balance_checker_top_test;
    import bbc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
    localparam int POS_CAP      = (DEF_MAX_LINE_LENGTH - 1 > POS_MAX) ?
                                  POS_MAX : DEF_MAX_LINE_LENGTH - 1;
    localparam int RANDOM_BEATS = 500;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // opener and closer bytes indexed by opener code
    localparam logic [3:0][SYM_W-1:0] OPEN_CHARS  = {CH_LBRACE, CH_LBRACK, CH_LANGLE, CH_LPAREN};
    localparam logic [3:0][SYM_W-1:0] CLOSE_CHARS = {CH_RBRACE, CH_RBRACK, CH_RANGLE, CH_RPAREN};

    // shapes of generated lines
    typedef enum int {
        LINE_BALANCED,
        LINE_OPEN,
        LINE_FULL,
        LINE_CORRUPT,
        LINE_NOISE,
        LINE_OVERFLOW
    } line_kind_t;

    // one character waiting to be sent
    typedef struct packed {
        in_beat_t   beat;
        logic       hold;   // wait for all results of earlier lines first
        logic [1:0] phase;
    } queued_char_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_beat_t   s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_data;

    queued_char_t char_queue[$];
    out_beat_t    expected_results[$];
    logic [SYM_W-1:0] line_buf[$];
    logic [1:0]   plan_opens[$];
    logic [1:0]   phase_now = 2'd0;

    // predictor state for the line in progress
    logic [1:0]       nest_codes[STACK_DEPTH];
    int unsigned      nest_depth;
    line_status_t     line_state;
    logic [POS_W-1:0] char_idx;
    logic [POS_W-1:0] fault_pos;
    logic [SYM_W-1:0] fault_sym;

    int unsigned errors = 0;
    int unsigned beats_in = 0;
    int unsigned results_checked = 0;
    int unsigned lines_done = 0;
    int unsigned closers_seen = 0;
    int unsigned status_seen[4];
    int unsigned cycles = 0;

    bracket_balance_checker_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned send_idle_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 37 : (ph == 2'd1) ? 84 : 0;
    endfunction

    function automatic int unsigned recv_idle_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 84 : (ph == 2'd1) ? 37 : 0;
    endfunction

    function automatic void mark_fault(input line_status_t cond, input logic [SYM_W-1:0] sym);
        line_state = cond;
        fault_pos  = char_idx;
        fault_sym  = sym;
    endfunction

    function automatic void clear_line_state();
        nest_depth = 0;
        line_state = LS_BALANCED;
        char_idx   = '0;
        fault_pos  = '0;
        fault_sym  = '0;
    endfunction

    // advance the line state by one character and queue the results it ends with
    function automatic void predict_results(input in_beat_t beat);
        out_beat_t r;
        int        code;
        int        k;
        code = -1;
        for (k = 0; k < 4; k++) begin
            if (OPEN_CHARS[k] == beat.symbol) code = k;
        end
        if (line_state == LS_BALANCED) begin
            if (code >= 0) begin
                if (nest_depth < STACK_DEPTH) begin
                    nest_codes[nest_depth] = code[1:0];
                    nest_depth++;
                end else begin
                    mark_fault(LS_OVERFLOW, beat.symbol);
                end
            end else if (nest_depth == 0) begin
                mark_fault(LS_CORRUPTED, beat.symbol);
            end else begin
                nest_depth--;
                if (CLOSE_CHARS[nest_codes[nest_depth]] != beat.symbol)
                    mark_fault(LS_CORRUPTED, beat.symbol);
            end
        end
        if (char_idx < POS_CAP) char_idx++;
        if (!beat.end_of_line) return;

        // status beat, then missing closers innermost first
        r = '0;
        r.result_kind  = RK_STATUS;
        r.final_result = 1'b1;
        if (line_state != LS_BALANCED) begin
            r.line_status      = line_state;
            r.error_position   = fault_pos;
            r.offending_symbol = fault_sym;
            expected_results.insert(expected_results.size(), r);
        end else if (nest_depth == 0) begin
            r.line_status = LS_BALANCED;
            expected_results.insert(expected_results.size(), r);
        end else begin
            r.line_status  = LS_INCOMPLETE;
            r.final_result = 1'b0;
            expected_results.insert(expected_results.size(), r);
            for (k = int'(nest_depth) - 1; k >= 0; k--) begin
                r.result_kind   = RK_CLOSER;
                r.closer_symbol = CLOSE_CHARS[nest_codes[k]];
                r.final_result  = (k == 0);
                expected_results.insert(expected_results.size(), r);
                closers_seen++;
            end
        end
        status_seen[r.line_status]++;
        lines_done++;
        clear_line_state();
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input out_beat_t got);
        out_beat_t want;
        if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        check_field("result_kind", want.result_kind, got.result_kind);
        check_field("line_status", want.line_status, got.line_status);
        check_field("error_position", want.error_position, got.error_position);
        check_field("offending_symbol", want.offending_symbol, got.offending_symbol);
        check_field("closer_symbol", want.closer_symbol, got.closer_symbol);
        check_field("final_result", want.final_result, got.final_result);
    endfunction

    // character source
    always @(posedge aclk) begin : driver
        queued_char_t next;
        logic         take;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_results(s_data);
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                take = 1'b0;
                if (char_queue.size() != 0) begin
                    take = ($urandom_range(99) >= send_idle_pct(char_queue[0].phase)) &&
                           !(char_queue[0].hold && expected_results.size() != 0);
                end
                if (take) begin
                    next = char_queue.pop_front();
                    s_data    <= next.beat;
                    phase_now <= next.phase;
                end
                s_valid <= take;
            end
        end
    end

    // result sink
    always @(posedge aclk) begin : monitor
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            m_ready <= ($urandom_range(99) >= recv_idle_pct(phase_now));
        end
    end

    // move the built line into the send queue, end of line on its last byte
    task automatic commit_line(input logic hold, input logic [1:0] ph);
        queued_char_t q;
        int           i;
        for (i = 0; i < line_buf.size(); i++) begin
            q.beat.symbol      = line_buf[i];
            q.beat.end_of_line = (i == line_buf.size() - 1);
            q.hold             = hold && (i == 0);
            q.phase            = ph;
            char_queue.insert(char_queue.size(), q);
        end
    endtask

    task automatic add_text(input string text);
        int i;
        line_buf.delete();
        for (i = 0; i < text.len(); i++) line_buf.insert(line_buf.size(), text[i]);
        commit_line(1'b0, 2'd0);
    endtask

    task automatic add_random_opener();
        logic [1:0] c;
        c = 2'($urandom_range(3));
        plan_opens.insert(plan_opens.size(), c);
        line_buf.insert(line_buf.size(), OPEN_CHARS[c]);
    endtask

    task automatic add_noise(input int unsigned count);
        repeat (count) line_buf.insert(line_buf.size(), SYM_W'($urandom_range(255)));
    endtask

    // remove and return the innermost planned opener
    function automatic logic [1:0] take_last_open();
        logic [1:0] c;
        c = plan_opens[$];
        plan_opens.delete(plan_opens.size() - 1);
        return c;
    endfunction

    function automatic line_kind_t pick_line_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return LINE_BALANCED;
        if (r < 52) return LINE_OPEN;
        if (r < 57) return LINE_FULL;
        if (r < 82) return LINE_CORRUPT;
        if (r < 94) return LINE_NOISE;
        return LINE_OVERFLOW;
    endfunction

    // well-formed prefix with random nesting, then an ending of the given shape; noise lines are random bytes only
    task automatic build_random_line(input line_kind_t kind);
        int unsigned body;
        int unsigned deep;
        logic [1:0]  c;
        line_buf.delete();
        plan_opens.delete();
        if (kind == LINE_NOISE) begin
            add_noise($urandom_range(1, 8));
            return;
        end
        body = $urandom_range(1, 14);
        deep = $urandom_range(1, 6);
        repeat (body) begin
            if (plan_opens.size() != 0 &&
                (plan_opens.size() >= deep || $urandom_range(1) == 0))
                line_buf.insert(line_buf.size(), CLOSE_CHARS[take_last_open()]);
            else
                add_random_opener();
        end
        case (kind)
            LINE_BALANCED: begin
                while (plan_opens.size() != 0)
                    line_buf.insert(line_buf.size(), CLOSE_CHARS[take_last_open()]);
            end
            LINE_OPEN: begin
                if (plan_opens.size() == 0) add_random_opener();
            end
            LINE_FULL: begin
                while (plan_opens.size() < STACK_DEPTH) add_random_opener();
            end
            LINE_OVERFLOW: begin
                while (plan_opens.size() <= STACK_DEPTH) add_random_opener();
                add_noise($urandom_range(3));
            end
            default: begin
                // wrong closer or arbitrary byte, then random bytes, ignored once the line has faulted
                if ($urandom_range(1) == 0) begin
                    line_buf.insert(line_buf.size(), SYM_W'($urandom_range(255)));
                end else begin
                    c = 2'($urandom_range(3));
                    if (plan_opens.size() != 0 && c == plan_opens[$]) c = c + 2'd1;
                    line_buf.insert(line_buf.size(), CLOSE_CHARS[c]);
                end
                add_noise($urandom_range(4));
            end
        endcase
    endtask

    initial begin : stimulus
        int unsigned rand_beats;
        int unsigned lines_built;
        logic [1:0]  ph;
        logic [1:0]  last_ph;
        line_kind_t  kind;
        int          i;
        clear_line_state();
        for (i = 0; i < 4; i++) status_seen[i] = 0;

        // directed lines
        add_text("()");
        add_text("<[{");
        add_text("(>");
        add_text(")");
        add_text("{a}");
        line_buf.delete();
        line_buf.insert(line_buf.size(), 8'h00);
        commit_line(1'b0, 2'd0);
        line_buf.delete();
        line_buf.insert(line_buf.size(), 8'hFF);
        commit_line(1'b0, 2'd0);
        add_text("[]<>{}");
        add_text("(");

        // random lines across the three stall profiles
        rand_beats  = 0;
        lines_built = 0;
        last_ph     = 2'd0;
        while (rand_beats < RANDOM_BEATS) begin
            ph = 2'(rand_beats * 3 / RANDOM_BEATS);
            if (lines_built == 0)
                kind = LINE_FULL;
            else if (lines_built == 1)
                kind = LINE_OVERFLOW;
            else
                kind = pick_line_kind();
            build_random_line(kind);
            commit_line((lines_built == 0) || (ph != last_ph) || ($urandom_range(19) == 0), ph);
            rand_beats += line_buf.size();
            lines_built++;
            last_ph = ph;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (char_queue.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d characters in %0d lines, %0d result beats checked",
                 beats_in, lines_done, results_checked);
        $display("summary: balanced %0d, corrupted %0d, incomplete %0d, overflow %0d, closers %0d",
                 status_seen[LS_BALANCED], status_seen[LS_CORRUPTED],
                 status_seen[LS_INCOMPLETE], status_seen[LS_OVERFLOW], closers_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
